>>> sv/dsd_to_pcm_fir_decimator_defines.svh
// Assertion macros for the DSD to PCM decimator.
// Used by the top level; relies on signals named clock and reset in scope.
`ifndef DSD_TO_PCM_FIR_DECIMATOR_DEFINES_SVH
`define DSD_TO_PCM_FIR_DECIMATOR_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define DTP_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define DTP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/dtp_pkg.sv
// Shared types and constants of the DSD to PCM decimator.
// No dependencies; used by the channel, front, back and top-level files.
package dtp_pkg;

   // field widths
   localparam int OPC_W      = 2;
   localparam int IDX_W      = 6;
   localparam int COEF_W     = 18;
   localparam int BYTE_W     = 8;
   localparam int PCM_W      = 24;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int RATIO_W    = 11;
   localparam int TAPSCFG_W  = 7;
   localparam int GAIN_W     = 16;

   // opcodes
   localparam logic [OPC_W-1:0] OP_LOAD  = 2'd0;
   localparam logic [OPC_W-1:0] OP_BYTE  = 2'd1;
   localparam logic [OPC_W-1:0] OP_CLEAR = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_RATIO = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TAPS  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN  = 2'd2;

   // register reset values
   localparam logic [RATIO_W-1:0]   RATIO_RST = 11'd128;
   localparam logic [TAPSCFG_W-1:0] TAPS_RST  = 7'd64;
   localparam logic [GAIN_W-1:0]    GAIN_RST  = 16'd4096;

   // PCM limits
   localparam logic signed [PCM_W-1:0] PCM_MAX = 24'sh7FFFFF;
   localparam logic signed [PCM_W-1:0] PCM_MIN = -24'sh800000;

   // command queue depth
   localparam int Q_DEPTH = 2;

   typedef struct packed {
      logic [OPC_W-1:0]         opcode;
      logic [IDX_W-1:0]         coef_index;
      logic signed [COEF_W-1:0] coef_value;
      logic [BYTE_W-1:0]        dsd_byte;
   } cmd_type;

   typedef struct packed {
      logic [RATIO_W-1:0]   ratio;
      logic [TAPSCFG_W-1:0] taps;
      logic [GAIN_W-1:0]    gain;
   } cfg_type;

   typedef struct packed {
      logic full;
   } fr_stat_type;

   typedef struct packed {
      logic idle;
   } bk_stat_type;

endpackage

>>> sv/dtp_channels.sv
// Handshake channel interfaces of the DSD to PCM decimator.
// Depends on dtp_pkg for field widths.
interface dtp_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [dtp_pkg::OPC_W-1:0]            opcode;
   logic [dtp_pkg::IDX_W-1:0]            coef_index;
   logic signed [dtp_pkg::COEF_W-1:0]    coef_value;
   logic [dtp_pkg::BYTE_W-1:0]           dsd_byte;
   modport source (output valid, opcode, coef_index, coef_value, dsd_byte, input ready);
   modport sink   (input valid, opcode, coef_index, coef_value, dsd_byte, output ready);
endinterface

interface dtp_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [dtp_pkg::PCM_W-1:0]  pcm_sample;
   logic                              saturated;
   logic                              last;
   modport source (output valid, pcm_sample, saturated, last, input ready);
   modport sink   (input valid, pcm_sample, saturated, last, output ready);
endinterface

interface dtp_csr_if;
   logic                               valid;
   logic                               ready;
   logic [dtp_pkg::CSR_IDX_W-1:0]      index;
   logic [dtp_pkg::CSR_DATA_W-1:0]     data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> sv/dtp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module dtp_ram #(
   parameter int WIDTH = 18,
   parameter int DEPTH = 64
) (
   input  logic                      clock,
   input  logic                      we,
   input  logic [$clog2(DEPTH)-1:0]  waddr,
   input  logic [WIDTH-1:0]          wdata,
   input  logic [$clog2(DEPTH)-1:0]  raddr,
   output logic [WIDTH-1:0]          rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> sv/dtp_front.sv
// Front end: accepts request items, drops unused opcodes, queues commands.
// Depends on dtp_pkg and dtp_channels.
module dtp_front (
   input  logic                  clock,
   input  logic                  reset,
   dtp_req_if.sink               req,
   output dtp_pkg::cmd_type      q_cmd,
   output logic                  q_valid,
   input  logic                  q_pop,
   output dtp_pkg::fr_stat_type  stat
);

   localparam int CW = $clog2(dtp_pkg::Q_DEPTH + 1);

   dtp_pkg::cmd_type slot_ff [dtp_pkg::Q_DEPTH];
   dtp_pkg::cmd_type slot_in [dtp_pkg::Q_DEPTH];
   logic [CW-1:0]    count_ff;
   logic [CW-1:0]    count_in;
   logic [CW-1:0]    wpos;
   logic             push;
   logic             pop;
   dtp_pkg::cmd_type cmd;

   assign req.ready = (count_ff != CW'(dtp_pkg::Q_DEPTH));
   assign cmd       = '{req.opcode, req.coef_index, req.coef_value, req.dsd_byte};

   // only known opcodes take a queue slot
   assign push = req.valid && req.ready &&
                 (req.opcode inside {dtp_pkg::OP_LOAD, dtp_pkg::OP_BYTE, dtp_pkg::OP_CLEAR});
   assign pop  = q_pop && q_valid;
   assign wpos = count_ff - CW'(pop);

   // shift queue: head at slot 0
   always_comb begin
      slot_in  = slot_ff;
      count_in = count_ff;
      if (pop) begin
         for (int i = 0; i < dtp_pkg::Q_DEPTH - 1; i++) begin
            slot_in[i] = slot_ff[i+1];
         end
      end
      if (push) begin
         slot_in[wpos[$clog2(dtp_pkg::Q_DEPTH)-1:0]] = cmd;
      end
      count_in = count_ff + CW'(push) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      slot_ff <= slot_in;
   end

   assign q_cmd     = slot_ff[0];
   assign q_valid   = (count_ff != '0);
   assign stat.full = (count_ff == CW'(dtp_pkg::Q_DEPTH));

endmodule

>>> sv/dtp_back.sv
// Back end: coefficient loads, history, serial FIR, decimation, scaling and
// a serial divider for the average; holds the result register.
// Depends on dtp_pkg, dtp_channels and dtp_ram.
module dtp_back #(
   parameter int TAPS      = 64,
   parameter int MAX_RATIO = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  dtp_pkg::cfg_type      cfg,
   input  dtp_pkg::cmd_type      q_cmd,
   input  logic                  q_valid,
   output logic                  q_pop,
   dtp_rsp_if.source             rsp,
   output dtp_pkg::bk_stat_type  stat
);

   localparam int TW   = $clog2(TAPS);
   localparam int FW   = $clog2(TAPS + 1);
   localparam int RW   = $clog2(MAX_RATIO + 1);
   localparam int AW   = dtp_pkg::COEF_W + $clog2(TAPS) + 1;
   localparam int SW   = AW + RW;
   localparam int LO_W = SW / 2;
   localparam int HI_W = SW - LO_W;
   localparam int GW   = dtp_pkg::GAIN_W;
   localparam int QW   = SW + GW + 1;
   localparam int MW   = QW;
   localparam int DW   = RW + 6;
   localparam int CW   = $clog2(MW);
   localparam int PW   = dtp_pkg::PCM_W;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_PUSH = 4'd1;
   localparam logic [3:0] S_FIR  = 4'd2;
   localparam logic [3:0] S_ACC  = 4'd3;
   localparam logic [3:0] S_MLO  = 4'd4;
   localparam logic [3:0] S_MHI  = 4'd5;
   localparam logic [3:0] S_SUM  = 4'd6;
   localparam logic [3:0] S_ABS  = 4'd7;
   localparam logic [3:0] S_DIV  = 4'd8;
   localparam logic [3:0] S_FIN  = 4'd9;
   localparam logic [3:0] S_OUT  = 4'd10;

   logic [3:0]                state_ff, state_in;
   logic [TAPS-1:0]           hist_ff, hist_in;
   logic [TAPS-1:0]           cval_ff, cval_in;
   logic [FW-1:0]             fill_ff, fill_in;
   logic [RW-1:0]             phase_ff, phase_in;
   logic signed [SW-1:0]      sum_ff, sum_in;
   logic [dtp_pkg::BYTE_W-1:0] byte_ff, byte_in;
   logic [2:0]                bit_ff, bit_in;
   logic [FW-1:0]             j_ff, j_in;
   logic                      pend_ff, pend_in;
   logic                      pbit_ff, pbit_in;
   logic                      pval_ff, pval_in;
   logic signed [AW-1:0]      acc_ff, acc_in;
   logic [LO_W+GW-1:0]        plo_ff, plo_in;
   logic signed [HI_W+GW:0]   phi_ff, phi_in;
   logic signed [QW-1:0]      n_ff, n_in;
   logic                      neg_ff, neg_in;
   logic [MW-1:0]             div_ff, div_in;
   logic [DW-1:0]             rem_ff, rem_in;
   logic [CW-1:0]             dcnt_ff, dcnt_in;
   logic signed [PW-1:0]      pcm_ff, pcm_in;
   logic                      sat_ff, sat_in;
   logic                      lastf_ff, lastf_in;
   logic                      rv_ff, rv_in;
   logic signed [PW-1:0]      rpcm_ff, rpcm_in;
   logic                      rsat_ff, rsat_in;
   logic                      rlast_ff, rlast_in;

   logic [RW-1:0]             ratio_eff;
   logic [FW-1:0]             taps_eff;
   logic [FW-1:0]             nterms;
   logic [DW-1:0]             divisor;
   logic                      ram_we;
   logic [TW-1:0]             ram_raddr;
   logic [dtp_pkg::COEF_W-1:0] ram_rdata;
   logic signed [dtp_pkg::COEF_W-1:0] coef_s;
   logic signed [SW-1:0]      sum_next;
   logic [RW-1:0]             phase_next;
   logic [DW:0]               trial;
   logic [MW:0]               qmag;
   logic signed [MW:0]        pfull;

   // register clamping
   always_comb begin
      if (cfg.ratio == '0) begin
         ratio_eff = RW'(1);
      end else if (32'(cfg.ratio) > 32'(MAX_RATIO)) begin
         ratio_eff = RW'(MAX_RATIO);
      end else begin
         ratio_eff = RW'(cfg.ratio);
      end
      if (cfg.taps == '0) begin
         taps_eff = FW'(1);
      end else if (32'(cfg.taps) > 32'(TAPS)) begin
         taps_eff = FW'(TAPS);
      end else begin
         taps_eff = FW'(cfg.taps);
      end
   end

   assign nterms  = (taps_eff < fill_ff) ? taps_eff : fill_ff;
   assign divisor = {ratio_eff, 6'b0};

   // coefficient store; valid bits make unwritten taps read as zero
   assign ram_we = (state_ff == S_IDLE) && q_valid && (q_cmd.opcode == dtp_pkg::OP_LOAD) &&
                   (32'(q_cmd.coef_index) < 32'(TAPS));

   dtp_ram #(.WIDTH(dtp_pkg::COEF_W), .DEPTH(TAPS)) u_coef (
      .clock (clock),
      .we    (ram_we),
      .waddr (TW'(q_cmd.coef_index)),
      .wdata (q_cmd.coef_value),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign coef_s     = pval_ff ? $signed(ram_rdata) : '0;
   assign sum_next   = sum_ff + SW'(acc_ff);
   assign phase_next = phase_ff + RW'(1);
   assign trial      = {rem_ff, div_ff[MW-1]};
   assign qmag       = {1'b0, div_ff} + (MW+1)'(neg_ff && (rem_ff != '0));
   assign pfull      = neg_ff ? -$signed(qmag) : $signed(qmag);

   // sequencer
   always_comb begin
      state_in  = state_ff;
      hist_in   = hist_ff;
      cval_in   = cval_ff;
      fill_in   = fill_ff;
      phase_in  = phase_ff;
      sum_in    = sum_ff;
      byte_in   = byte_ff;
      bit_in    = bit_ff;
      j_in      = j_ff;
      pend_in   = 1'b0;
      pbit_in   = pbit_ff;
      pval_in   = pval_ff;
      acc_in    = acc_ff;
      plo_in    = plo_ff;
      phi_in    = phi_ff;
      n_in      = n_ff;
      neg_in    = neg_ff;
      div_in    = div_ff;
      rem_in    = rem_ff;
      dcnt_in   = dcnt_ff;
      pcm_in    = pcm_ff;
      sat_in    = sat_ff;
      lastf_in  = lastf_ff;
      rpcm_in   = rpcm_ff;
      rsat_in   = rsat_ff;
      rlast_in  = rlast_ff;
      rv_in     = rv_ff && !rsp.ready;
      q_pop     = 1'b0;
      ram_raddr = TW'(j_ff);

      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               case (q_cmd.opcode)
                  dtp_pkg::OP_LOAD: begin
                     if (ram_we) begin
                        cval_in[TW'(q_cmd.coef_index)] = 1'b1;
                     end
                  end
                  dtp_pkg::OP_BYTE: begin
                     byte_in  = q_cmd.dsd_byte;
                     bit_in   = '0;
                     state_in = S_PUSH;
                  end
                  dtp_pkg::OP_CLEAR: begin
                     hist_in  = '0;
                     fill_in  = '0;
                     phase_in = '0;
                     sum_in   = '0;
                  end
                  default: ;
               endcase
            end
         end
         // shift the oldest remaining DSD bit into the history
         S_PUSH: begin
            hist_in = {hist_ff[TAPS-2:0], byte_ff[dtp_pkg::BYTE_W-1]};
            byte_in = byte_ff << 1;
            if (fill_ff < FW'(TAPS)) begin
               fill_in = fill_ff + FW'(1);
            end
            j_in     = '0;
            acc_in   = '0;
            state_in = S_FIR;
         end
         // one tap per cycle; the registered coefficient read lands in the next cycle
         S_FIR: begin
            if (j_ff < nterms) begin
               pend_in = 1'b1;
               pbit_in = hist_ff[TW'(j_ff)];
               pval_in = cval_ff[TW'(j_ff)];
               j_in    = j_ff + FW'(1);
            end
            if (pend_ff) begin
               acc_in = pbit_ff ? acc_ff + AW'(coef_s) : acc_ff - AW'(coef_s);
            end
            if (!pend_ff && (j_ff >= nterms)) begin
               state_in = S_ACC;
            end
         end
         S_ACC: begin
            sum_in = sum_next;
            if (phase_next >= ratio_eff) begin
               lastf_in = 32'(3'd7 - bit_ff) < 32'(ratio_eff);
               state_in = S_MLO;
            end else begin
               phase_in = phase_next;
               if (bit_ff == 3'd7) begin
                  state_in = S_IDLE;
               end else begin
                  bit_in   = bit_ff + 3'd1;
                  state_in = S_PUSH;
               end
            end
         end
         // sum * gain in two partial products
         S_MLO: begin
            plo_in   = (LO_W+GW)'(sum_ff[LO_W-1:0]) * (LO_W+GW)'(cfg.gain);
            state_in = S_MHI;
         end
         S_MHI: begin
            phi_in   = $signed(sum_ff[SW-1:LO_W]) * $signed({1'b0, cfg.gain});
            state_in = S_SUM;
         end
         // add rounding offset of half the divisor
         S_SUM: begin
            n_in = (QW'(phi_ff) <<< LO_W) + $signed(QW'(plo_ff)) +
                   $signed(QW'({ratio_eff, 5'b0}));
            state_in = S_ABS;
         end
         S_ABS: begin
            neg_in   = n_ff[QW-1];
            div_in   = n_ff[QW-1] ? MW'(-n_ff) : MW'(n_ff);
            rem_in   = '0;
            dcnt_in  = '0;
            state_in = S_DIV;
         end
         // restoring division, one quotient bit per cycle
         S_DIV: begin
            if (trial >= {1'b0, divisor}) begin
               rem_in = DW'(trial - {1'b0, divisor});
               div_in = {div_ff[MW-2:0], 1'b1};
            end else begin
               rem_in = DW'(trial);
               div_in = {div_ff[MW-2:0], 1'b0};
            end
            dcnt_in = dcnt_ff + CW'(1);
            if (dcnt_ff == CW'(MW - 1)) begin
               state_in = S_FIN;
            end
         end
         // floor for negatives, then clamp to PCM range
         S_FIN: begin
            if (pfull > (MW+1)'(dtp_pkg::PCM_MAX)) begin
               pcm_in = dtp_pkg::PCM_MAX;
               sat_in = 1'b1;
            end else if (pfull < (MW+1)'(dtp_pkg::PCM_MIN)) begin
               pcm_in = dtp_pkg::PCM_MIN;
               sat_in = 1'b1;
            end else begin
               pcm_in = PW'(pfull);
               sat_in = 1'b0;
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rv_ff || rsp.ready) begin
               rv_in    = 1'b1;
               rpcm_in  = pcm_ff;
               rsat_in  = sat_ff;
               rlast_in = lastf_ff;
               phase_in = '0;
               sum_in   = '0;
               if (bit_ff == 3'd7) begin
                  state_in = S_IDLE;
               end else begin
                  bit_in   = bit_ff + 3'd1;
                  state_in = S_PUSH;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         hist_ff  <= '0;
         cval_ff  <= '0;
         fill_ff  <= '0;
         phase_ff <= '0;
         sum_ff   <= '0;
         pend_ff  <= 1'b0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         hist_ff  <= hist_in;
         cval_ff  <= cval_in;
         fill_ff  <= fill_in;
         phase_ff <= phase_in;
         sum_ff   <= sum_in;
         pend_ff  <= pend_in;
         rv_ff    <= rv_in;
      end
      byte_ff  <= byte_in;
      bit_ff   <= bit_in;
      j_ff     <= j_in;
      pbit_ff  <= pbit_in;
      pval_ff  <= pval_in;
      acc_ff   <= acc_in;
      plo_ff   <= plo_in;
      phi_ff   <= phi_in;
      n_ff     <= n_in;
      neg_ff   <= neg_in;
      div_ff   <= div_in;
      rem_ff   <= rem_in;
      dcnt_ff  <= dcnt_in;
      pcm_ff   <= pcm_in;
      sat_ff   <= sat_in;
      lastf_ff <= lastf_in;
      rpcm_ff  <= rpcm_in;
      rsat_ff  <= rsat_in;
      rlast_ff <= rlast_in;
   end

   assign rsp.valid      = rv_ff;
   assign rsp.pcm_sample = rpcm_ff;
   assign rsp.saturated  = rsat_ff;
   assign rsp.last       = rlast_ff;
   assign stat.idle      = (state_ff == S_IDLE);

endmodule

>>> sv/dsd_to_pcm_fir_decimator.sv
// Top level of the DSD to PCM FIR decimator: registers, front queue, back end.
// Depends on dtp_pkg, dtp_channels, dtp_front, dtp_back and the defines header.
//
//   channel  | dir | handshake   | carries
//   req_ch   | in  | valid/ready | opcode, coef_index, coef_value, dsd_byte
//   rsp_ch   | out | valid/ready | pcm_sample, saturated, last
//   csr_ch   | in  | valid/ready | index, data (ready always high)
//
// Each bit of a byte runs the single-tap FIR loop over N = min(active taps,
// filled history) taps, reading the coefficient RAM; each PCM result then
// passes the partial-product, sum, magnitude, bit-serial divider, clamp and
// output states plus any wait on rsp_ch.ready. Loads and clears end in idle.
// Reset is synchronous; it clears history, coefficients and registers at once.
// A two-item queue lets requests land while the back end works or the
// result register waits on rsp_ch.ready.
`include "dsd_to_pcm_fir_decimator_defines.svh"

module dsd_to_pcm_fir_decimator #(
   parameter int TAPS      = 64,
   parameter int MAX_RATIO = 1024
) (
   input  logic        clock,
   input  logic        reset,
   dtp_req_if.sink     req_ch,
   dtp_rsp_if.source   rsp_ch,
   dtp_csr_if.sink     csr_ch
);

   dtp_pkg::cfg_type     cfg_ff, cfg_in;
   dtp_pkg::cmd_type     q_cmd;
   logic                 q_valid;
   logic                 q_pop;
   dtp_pkg::fr_stat_type fr_stat;
   dtp_pkg::bk_stat_type bk_stat;

   // configuration registers
   assign csr_ch.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            dtp_pkg::CSR_RATIO: cfg_in.ratio = csr_ch.data[dtp_pkg::RATIO_W-1:0];
            dtp_pkg::CSR_TAPS:  cfg_in.taps  = csr_ch.data[dtp_pkg::TAPSCFG_W-1:0];
            dtp_pkg::CSR_GAIN:  cfg_in.gain  = csr_ch.data[dtp_pkg::GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{dtp_pkg::RATIO_RST, dtp_pkg::TAPS_RST, dtp_pkg::GAIN_RST};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   dtp_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req     (req_ch),
      .q_cmd   (q_cmd),
      .q_valid (q_valid),
      .q_pop   (q_pop),
      .stat    (fr_stat)
   );

   dtp_back #(.TAPS(TAPS), .MAX_RATIO(MAX_RATIO)) u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .q_cmd   (q_cmd),
      .q_valid (q_valid),
      .q_pop   (q_pop),
      .rsp     (rsp_ch),
      .stat    (bk_stat)
   );

   // checks
   `DTP_ASSERT_NOW(a_full_stalls, fr_stat.full, !req_ch.ready, "request taken while queue full")
   `DTP_ASSERT_NEXT(a_idle_waits, bk_stat.idle && !q_valid, bk_stat.idle, "back left idle w/o item")
   `DTP_ASSERT_NOW(a_pop_when_idle, q_pop, bk_stat.idle && q_valid, "queue popped while busy")

endmodule
